/* hw/rtl/npm_pkg.sv */
// Shared types and constants for the nearest-point search block.
package npm_pkg;

    localparam int WPC_W          = 7;
    localparam int IDX_OUT_W      = 6;
    localparam int COORD_W        = 16;
    localparam int SHIFT          = 6;
    localparam int COARSE_W       = COORD_W - SHIFT;
    localparam int DIFF_W         = COORD_W + 1;
    localparam int ABS_W          = COORD_W;
    localparam int DIST_W         = 17;
    localparam int DIST_MAX       = 3 * ((1 << (COORD_W - 1)) + (1 << (COARSE_W - 1)) - 1);
    localparam int MAX_POINTS_DEF = 64;

    localparam int IN_DATA_W      = 56;
    localparam int IN_USER_W      = 1;
    localparam int OUT_DATA_W     = 24;
    localparam int OUT_USER_W     = 1;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;

    localparam logic REG_WAYPOINT_COUNT = 1'b0;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_point;

    typedef struct packed {
        logic signed [COARSE_W-1:0] z;
        logic signed [COARSE_W-1:0] y;
        logic signed [COARSE_W-1:0] x;
    } t_query;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_scan_ctl;

endpackage

/* hw/rtl/npm_store.sv */
// Point table: one write port, one registered read port with control alongside.
module npm_store #(
    parameter int DEPTH = npm_pkg::MAX_POINTS_DEF,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [IDX_W-1:0]   i_wr_addr,
    input  npm_pkg::t_point    i_wr_data,
    input  npm_pkg::t_scan_ctl i_rd_ctl,
    input  logic [IDX_W-1:0]   i_rd_addr,
    output npm_pkg::t_point    o_rd_data,
    output npm_pkg::t_scan_ctl o_rd_ctl
);

    npm_pkg::t_point    r_mem [DEPTH];
    npm_pkg::t_point    r_rd_data;
    npm_pkg::t_scan_ctl r_rd_ctl;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_ctl.valid) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ctl <= '0;
        end else begin
            r_rd_ctl <= i_rd_ctl;
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_ctl  = r_rd_ctl;

endmodule

/* hw/rtl/npm_dist_unit.sv */
// Shared distance unit: absolute differences, then sum and running minimum.
module npm_dist_unit #(
    parameter int IDX_W = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  npm_pkg::t_query             i_query,
    input  npm_pkg::t_point             i_point,
    input  npm_pkg::t_scan_ctl          i_ctl,
    output logic                        o_done,
    output logic [npm_pkg::DIST_W-1:0]  o_best,
    output logic [IDX_W-1:0]            o_best_idx
);

    logic signed [npm_pkg::DIFF_W-1:0] dx, dy, dz;
    logic signed [npm_pkg::DIFF_W-1:0] nx, ny, nz;
    logic [npm_pkg::ABS_W-1:0]         ax, ay, az;
    logic [npm_pkg::DIST_W-1:0]        sum;
    logic [IDX_W-1:0]                  cur_idx;

    logic [npm_pkg::ABS_W-1:0]  r_ax, r_ay, r_az;
    npm_pkg::t_scan_ctl         r_ctl;
    logic [IDX_W-1:0]           r_idx;
    logic [npm_pkg::DIST_W-1:0] r_best;
    logic [IDX_W-1:0]           r_best_idx;
    logic                       r_done;

    always_comb begin
        dx = npm_pkg::DIFF_W'(i_point.x) - npm_pkg::DIFF_W'(i_query.x);
        dy = npm_pkg::DIFF_W'(i_point.y) - npm_pkg::DIFF_W'(i_query.y);
        dz = npm_pkg::DIFF_W'(i_point.z) - npm_pkg::DIFF_W'(i_query.z);
        nx = -dx;
        ny = -dy;
        nz = -dz;
        ax = dx[npm_pkg::DIFF_W-1] ? nx[npm_pkg::ABS_W-1:0] : dx[npm_pkg::ABS_W-1:0];
        ay = dy[npm_pkg::DIFF_W-1] ? ny[npm_pkg::ABS_W-1:0] : dy[npm_pkg::ABS_W-1:0];
        az = dz[npm_pkg::DIFF_W-1] ? nz[npm_pkg::ABS_W-1:0] : dz[npm_pkg::ABS_W-1:0];
    end

    assign sum = npm_pkg::DIST_W'(r_ax) + npm_pkg::DIST_W'(r_ay) + npm_pkg::DIST_W'(r_az);
    assign cur_idx = r_ctl.first ? '0 : r_idx;

    always_ff @(posedge i_clk) begin
        r_ax <= ax;
        r_ay <= ay;
        r_az <= az;
        if (r_ctl.valid) begin
            r_idx <= cur_idx + IDX_W'(1);
            if (r_ctl.first || (sum < r_best)) begin
                r_best     <= sum;
                r_best_idx <= cur_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl  <= i_ctl;
            r_done <= r_ctl.valid && r_ctl.last;
        end
    end

    assign o_done     = r_done;
    assign o_best     = r_best;
    assign o_best_idx = r_best_idx;

endmodule

/* hw/rtl/nearest_point_manhattan.sv */
// Top level: nearest stored point to a query by Manhattan distance.
//
//   channel   direction  transfer when                  contents
//   s_axis    in         tvalid & tready                load entry or query
//   m_axis    out        tvalid & tready                nearest index, distance, found
//   apb       in/out     psel & penable & pwrite        waypoint_count at address 0
//
// A load is written to the table as it is accepted. A query walks the table one entry per cycle,
// n = min(waypoint_count, MAX_POINTS) entries, through the table read port and the shared
// distance unit; an empty search skips the walk and goes straight to the output register.
// Reset is synchronous and clears control only; the table holds garbage until loaded.
// A query result waits in the output register; tready stays low until the result is placed there.
module nearest_point_manhattan #(
    parameter int MAX_POINTS = npm_pkg::MAX_POINTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // entry_index[5:0], pos_x[21:6], pos_y[37:22], pos_z[53:38], zero[55:54]
    input  logic [npm_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // command[0]
    input  logic [npm_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // nearest_index[5:0], best_distance[22:6], zero[23]
    output logic [npm_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // found[0]
    output logic [npm_pkg::OUT_USER_W-1:0]  o_m_axis_tuser,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [npm_pkg::APB_ADDR_W-1:0]  i_paddr,
    input  logic [npm_pkg::APB_DATA_W-1:0]  i_pwdata,
    output logic [npm_pkg::APB_DATA_W-1:0]  o_prdata,
    output logic                            o_pready
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CMP_W = (CNT_W > npm_pkg::WPC_W) ? CNT_W : npm_pkg::WPC_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state                          r_state;
    logic [npm_pkg::WPC_W-1:0]       r_wpc;
    npm_pkg::t_query                 r_query;
    logic [IDX_W-1:0]                r_addr;
    logic [IDX_W-1:0]                r_last;
    logic                            r_empty;
    logic                            r_out_valid;
    logic [npm_pkg::IDX_OUT_W-1:0]   r_out_idx;
    logic [npm_pkg::DIST_W-1:0]      r_out_dist;
    logic                            r_out_found;

    npm_pkg::t_cmd                   in_cmd;
    logic [npm_pkg::IDX_OUT_W-1:0]   in_idx;
    npm_pkg::t_point                 in_point;
    npm_pkg::t_query                 in_query;
    logic                            in_xfer;
    logic                            out_xfer;
    logic                            cfg_wr;
    logic                            cfg_idx;
    logic [CMP_W-1:0]                wpc_ext;
    logic [CMP_W-1:0]                n_sat;
    logic [CMP_W-1:0]                n_last;
    logic                            wr_en;
    npm_pkg::t_scan_ctl              rd_ctl;
    npm_pkg::t_point                 mem_data;
    npm_pkg::t_scan_ctl              mem_ctl;
    logic                            dist_done;
    logic [npm_pkg::DIST_W-1:0]      dist_best;
    logic [IDX_W-1:0]                dist_best_idx;

    assign in_cmd     = npm_pkg::t_cmd'(i_s_axis_tuser[0]);
    assign in_idx     = i_s_axis_tdata[5:0];
    assign in_point.x = i_s_axis_tdata[21:6];
    assign in_point.y = i_s_axis_tdata[37:22];
    assign in_point.z = i_s_axis_tdata[53:38];
    assign in_query.x = in_point.x[npm_pkg::COORD_W-1:npm_pkg::SHIFT];
    assign in_query.y = in_point.y[npm_pkg::COORD_W-1:npm_pkg::SHIFT];
    assign in_query.z = in_point.z[npm_pkg::COORD_W-1:npm_pkg::SHIFT];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer = r_out_valid && i_m_axis_tready;

    assign wpc_ext = CMP_W'(r_wpc);
    assign n_sat   = (wpc_ext > CMP_W'(MAX_POINTS)) ? CMP_W'(MAX_POINTS) : wpc_ext;
    assign n_last  = n_sat - CMP_W'(1);

    assign wr_en = in_xfer && (in_cmd == npm_pkg::CMD_LOAD)
                && (CMP_W'(in_idx) < CMP_W'(MAX_POINTS));

    assign rd_ctl.valid = (r_state == S_SCAN);
    assign rd_ctl.first = (r_addr == '0);
    assign rd_ctl.last  = (r_addr == r_last);

    // APB register access
    assign o_pready = 1'b1;
    assign cfg_idx  = i_paddr[2];
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;

    always_comb begin
        o_prdata = '0;
        unique case (cfg_idx)
            npm_pkg::REG_WAYPOINT_COUNT: o_prdata = npm_pkg::APB_DATA_W'(r_wpc);
            default:                     o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpc <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                npm_pkg::REG_WAYPOINT_COUNT: r_wpc <= i_pwdata[npm_pkg::WPC_W-1:0];
                default: ;
            endcase
        end
    end

    npm_store #(
        .DEPTH (MAX_POINTS),
        .IDX_W (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (IDX_W'(in_idx)),
        .i_wr_data (in_point),
        .i_rd_ctl  (rd_ctl),
        .i_rd_addr (r_addr),
        .o_rd_data (mem_data),
        .o_rd_ctl  (mem_ctl)
    );

    npm_dist_unit #(
        .IDX_W (IDX_W)
    ) u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_query    (r_query),
        .i_point    (mem_data),
        .i_ctl      (mem_ctl),
        .o_done     (dist_done),
        .o_best     (dist_best),
        .o_best_idx (dist_best_idx)
    );

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_empty     <= 1'b0;
            r_addr      <= '0;
            r_last      <= '0;
        end else begin
            if (out_xfer && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && (in_cmd == npm_pkg::CMD_QUERY)) begin
                        r_query <= in_query;
                        r_addr  <= '0;
                        r_last  <= IDX_W'(n_last);
                        r_empty <= (n_sat == '0);
                        r_state <= (n_sat == '0) ? S_OUT : S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_addr <= r_addr + IDX_W'(1);
                    if (rd_ctl.last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (dist_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_found <= !r_empty;
                        r_out_idx   <= r_empty ? '0 : npm_pkg::IDX_OUT_W'(dist_best_idx);
                        r_out_dist  <= r_empty ? '0 : dist_best;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_dist, r_out_idx};
    assign o_m_axis_tuser  = r_out_found;

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found) |-> (r_out_idx == '0 && r_out_dist == '0))
        else $error("empty search result carries nonzero fields");

    a_done_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dist_done |-> (r_state == S_DRAIN))
        else $error("distance unit finished outside drain");

    a_addr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= r_last))
        else $error("scan address beyond last entry");

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_dist <= npm_pkg::DIST_W'(npm_pkg::DIST_MAX)))
        else $error("distance above largest possible sum");

endmodule

/* sim/tb_top.sv */
// Testbench for nearest_point_manhattan: load/query stream against a nearest-point predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int N_PTS         = npm_pkg::MAX_POINTS_DEF;
    localparam int SETTLE_CYCLES = N_PTS + 16;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int REG_UNUSED    = 1;
    localparam logic [npm_pkg::APB_ADDR_W-1:0] ADDR_WPC    =
        npm_pkg::APB_ADDR_W'(4 * int'(npm_pkg::REG_WAYPOINT_COUNT));
    localparam logic [npm_pkg::APB_ADDR_W-1:0] ADDR_UNUSED =
        npm_pkg::APB_ADDR_W'(4 * REG_UNUSED);

    typedef struct packed {
        logic [npm_pkg::IDX_OUT_W-1:0] index;
        logic [npm_pkg::DIST_W-1:0]    distance;
        logic                          found;
    } t_nearest;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_s_axis_tvalid = 1'b0;
    logic                                o_s_axis_tready;
    // entry_index[5:0], pos_x[21:6], pos_y[37:22], pos_z[53:38], zero[55:54]
    logic [npm_pkg::IN_DATA_W-1:0]       i_s_axis_tdata = '0;
    // command[0]
    logic [npm_pkg::IN_USER_W-1:0]       i_s_axis_tuser = '0;
    logic                                o_m_axis_tvalid;
    logic                                i_m_axis_tready = 1'b0;
    // nearest_index[5:0], best_distance[22:6], zero[23]
    logic [npm_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata;
    // found[0]
    logic [npm_pkg::OUT_USER_W-1:0]      o_m_axis_tuser;
    logic                                i_psel = 1'b0;
    logic                                i_penable = 1'b0;
    logic                                i_pwrite = 1'b0;
    logic [npm_pkg::APB_ADDR_W-1:0]      i_paddr = '0;
    logic [npm_pkg::APB_DATA_W-1:0]      i_pwdata = '0;
    logic [npm_pkg::APB_DATA_W-1:0]      o_prdata;
    logic                                o_pready;

    npm_pkg::t_point           shadow_pts [N_PTS];
    logic [npm_pkg::WPC_W-1:0] search_count = '0;
    t_nearest    pending_nearest [$];
    int          mismatches = 0;
    int          cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          hold_request = 0;
    int          hold_left = 0;

    nearest_point_manhattan uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_psel          (i_psel),
        .i_penable       (i_penable),
        .i_pwrite        (i_pwrite),
        .i_paddr         (i_paddr),
        .i_pwdata        (i_pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic int absdiff(input int a, input int b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic t_nearest nearest_point(input npm_pkg::t_point q);
        t_nearest r;
        int qx, qy, qz, n, d, best;
        r    = '0;
        best = 0;
        qx   = int'(q.x) >>> npm_pkg::SHIFT;
        qy   = int'(q.y) >>> npm_pkg::SHIFT;
        qz   = int'(q.z) >>> npm_pkg::SHIFT;
        n    = (int'(search_count) > N_PTS) ? N_PTS : int'(search_count);
        for (int i = 0; i < n; i++) begin
            d = absdiff(qx, int'(shadow_pts[i].x)) + absdiff(qy, int'(shadow_pts[i].y))
                + absdiff(qz, int'(shadow_pts[i].z));
            if (!r.found || d < best) begin
                r.found = 1'b1;
                best    = d;
                r.index = npm_pkg::IDX_OUT_W'(i);
            end
        end
        r.distance = npm_pkg::DIST_W'(best);
        return r;
    endfunction

    // check results, then predict from the input transfer of the same edge
    always @(posedge i_clk) begin
        t_nearest        want;
        npm_pkg::t_point p;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_nearest.size() == 0) begin
                    $display("%0t: unexpected result index %0d distance %0d found %0d", $time,
                             o_m_axis_tdata[5:0], o_m_axis_tdata[22:6], o_m_axis_tuser[0]);
                    mismatches++;
                end else begin
                    want = pending_nearest.pop_front();
                    if (o_m_axis_tdata[5:0] !== want.index) begin
                        $display("%0t: nearest_index expected %0d actual %0d", $time,
                                 want.index, o_m_axis_tdata[5:0]);
                        mismatches++;
                    end
                    if (o_m_axis_tdata[22:6] !== want.distance) begin
                        $display("%0t: best_distance expected %0d actual %0d", $time,
                                 want.distance, o_m_axis_tdata[22:6]);
                        mismatches++;
                    end
                    if (o_m_axis_tuser[0] !== want.found) begin
                        $display("%0t: found expected %0d actual %0d", $time,
                                 want.found, o_m_axis_tuser[0]);
                        mismatches++;
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                p = npm_pkg::t_point'({i_s_axis_tdata[53:38], i_s_axis_tdata[37:22],
                                       i_s_axis_tdata[21:6]});
                if (npm_pkg::t_cmd'(i_s_axis_tuser[0]) == npm_pkg::CMD_QUERY)
                    pending_nearest.push_back(nearest_point(p));
                else
                    shadow_pts[i_s_axis_tdata[5:0]] = p;
            end
            if (i_psel && i_penable && i_pwrite && o_pready && i_paddr == ADDR_WPC)
                search_count = i_pwdata[npm_pkg::WPC_W-1:0];
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_item(input npm_pkg::t_cmd cmd, input int idx,
                             input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, z, y, x, npm_pkg::IDX_OUT_W'(idx)};
        i_s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_nearest.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [npm_pkg::APB_ADDR_W-1:0] addr,
                             input logic [31:0] data);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= addr;
        i_pwdata  <= data;
        @(negedge i_clk);
        i_penable <= 1'b1;
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    task automatic apb_read_check(input logic [npm_pkg::APB_ADDR_W-1:0] addr,
                                  input logic [31:0] want);
        @(negedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        i_paddr   <= addr;
        @(negedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        if (o_prdata !== want) begin
            $display("%0t: register read expected %0d actual %0d", $time, want, o_prdata);
            mismatches++;
        end
        @(negedge i_clk);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
    endtask

    task automatic set_search_count(input int count);
        wait_idle();
        apb_write(ADDR_WPC, 32'(count));
        apb_read_check(ADDR_WPC, 32'(count));
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(3))
            0: return 16'($urandom());
            1, 2: return 16'(int'($urandom_range(1200)) - 600);
            default: return $urandom_range(1) ? 16'h7fff : 16'h8000;
        endcase
    endfunction

    task automatic random_item();
        int n, i;
        npm_pkg::t_point p;
        n = (int'(search_count) > N_PTS) ? N_PTS : int'(search_count);
        if ($urandom_range(99) < 55) begin
            if (n > 0 && $urandom_range(99) < 60) begin
                // land near a stored point so that the search is close
                p = shadow_pts[$urandom_range(n - 1)];
                send_item(npm_pkg::CMD_QUERY, $urandom_range(63),
                          16'(int'(p.x) * 64 + int'($urandom_range(63))),
                          16'(int'(p.y) * 64 + int'($urandom_range(63))),
                          16'(int'(p.z) * 64 + int'($urandom_range(63))));
            end else begin
                send_item(npm_pkg::CMD_QUERY, $urandom_range(63), rand_coord(), rand_coord(),
                          rand_coord());
            end
        end else begin
            i = $urandom_range(N_PTS - 1);
            if ($urandom_range(99) < 25) begin
                // duplicate another entry to force a tie
                p = shadow_pts[$urandom_range(N_PTS - 1)];
                send_item(npm_pkg::CMD_LOAD, i, p.x, p.y, p.z);
            end else begin
                send_item(npm_pkg::CMD_LOAD, i, rand_coord(), rand_coord(), rand_coord());
            end
        end
    endtask

    task automatic test_empty_search();
        set_search_count(0);
        send_item(npm_pkg::CMD_QUERY, 0, 16'h7fff, 16'h8000, 16'h0000);
        send_item(npm_pkg::CMD_QUERY, 63, 16'hffff, 16'h0040, 16'h8000);
    endtask

    task automatic test_unused_register();
        wait_idle();
        apb_write(ADDR_UNUSED, 32'd5);
        apb_read_check(ADDR_WPC, 32'(search_count));
        send_item(npm_pkg::CMD_QUERY, 5, 16'h0000, 16'h0000, 16'h0000);
    endtask

    task automatic test_extremes();
        send_item(npm_pkg::CMD_LOAD, 0, 16'h8000, 16'h8000, 16'h8000);
        send_item(npm_pkg::CMD_LOAD, 1, 16'h7fff, 16'h7fff, 16'h7fff);
        send_item(npm_pkg::CMD_LOAD, 2, 16'h0000, 16'h0000, 16'h0000);
        send_item(npm_pkg::CMD_LOAD, 3, 16'h0000, 16'h0000, 16'h0000);
        send_item(npm_pkg::CMD_LOAD, 63, 16'h7fff, 16'h8000, 16'h5555);
        set_search_count(1);
        send_item(npm_pkg::CMD_QUERY, 0, 16'h7fff, 16'h7fff, 16'h7fff);
        send_item(npm_pkg::CMD_QUERY, 0, 16'h8000, 16'h8000, 16'h8000);
        set_search_count(4);
        send_item(npm_pkg::CMD_QUERY, 0, 16'h0000, 16'h0000, 16'h0000);
        send_item(npm_pkg::CMD_QUERY, 63, 16'hffff, 16'hffff, 16'hffff);
        send_item(npm_pkg::CMD_QUERY, 0, 16'h7fff, 16'h7fff, 16'h7fff);
        send_item(npm_pkg::CMD_QUERY, 0, 16'h8000, 16'h8000, 16'h8000);
        send_item(npm_pkg::CMD_QUERY, 42, 16'h0040, 16'hffc0, 16'h003f);
        set_search_count(3);
        send_item(npm_pkg::CMD_QUERY, 21, 16'h0000, 16'h0000, 16'h0000);
    endtask

    task automatic test_fill();
        for (int i = 0; i < N_PTS; i++)
            send_item(npm_pkg::CMD_LOAD, i, rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic test_random(input int count, input int items);
        set_search_count(count);
        repeat (items) random_item();
    endtask

    task automatic test_backpressure();
        set_search_count(100);
        hold_request = 400;
        repeat (30) random_item();
        wait_idle();
    endtask

    initial begin
        tx_idle_pct = 22;
        rx_idle_pct = 78;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_search();
        test_unused_register();
        test_extremes();
        test_fill();
        test_random(64, 160);
        tx_idle_pct = 78;
        rx_idle_pct = 22;
        test_random(127, 140);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(1, 50);
        test_backpressure();
        test_random($urandom_range(2, 63), 120);
        test_random(64, 60);
        wait_idle();
        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
